@@ design/pevb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pevb_pkg: shared types and constants of the pointer event buffer
// Command codes, decoded operations and the queued item format.
// ----------------------------------------------------------------------------
package pevb_pkg;

	localparam int RING_DEPTH_DEF = 5;
	localparam int QUEUE_DEPTH = 2;
	localparam logic signed [15:0] FRAME_X_RESET = 16'sd320;
	localparam logic signed [15:0] FRAME_Y_RESET = 16'sd240;

	typedef enum logic [3:0] {
		CMD_MOVE        = 4'd0,
		CMD_LDOWN       = 4'd1,
		CMD_LUP         = 4'd2,
		CMD_RDOWN       = 4'd3,
		CMD_RUP         = 4'd4,
		CMD_WHEEL       = 4'd5,
		CMD_FRAME       = 4'd6,
		CMD_HELD_HIT    = 4'd7,
		CMD_CLICK_HIT   = 4'd8,
		CMD_CURSOR_HIT  = 4'd9,
		CMD_FORCE_CLICK = 4'd10,
		CMD_FORCE_HELD  = 4'd11
	} cmd_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_MOVE,
		OP_LDOWN,
		OP_LUP,
		OP_RDOWN,
		OP_RUP,
		OP_WHEEL,
		OP_FRAME,
		OP_HIT_HELD,
		OP_HIT_CLICK,
		OP_HIT_CURSOR,
		OP_FORCE_CLICK,
		OP_FORCE_HELD
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [1:0]         move_buttons;
		logic signed [15:0] wheel_in;
		logic signed [15:0] rect_left;
		logic signed [15:0] rect_top;
		logic signed [15:0] rect_right;
		logic signed [15:0] rect_bottom;
		logic [1:0]         button_mask;
	} item_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

@@ design/pevb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pevb_front: command classifier
// Turns a raw command and focus bit into a decoded operation for the queue.
// ----------------------------------------------------------------------------
module pevb_front
	import pevb_pkg::*;
(
	input  wire logic               in_valid,
	input  wire q_stat_t            q_stat,
	input  wire logic [3:0]         cmd,
	input  wire logic               focused,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic [1:0]         move_buttons,
	input  wire logic signed [15:0] wheel_in,
	input  wire logic signed [15:0] rect_left,
	input  wire logic signed [15:0] rect_top,
	input  wire logic signed [15:0] rect_right,
	input  wire logic signed [15:0] rect_bottom,
	input  wire logic [1:0]         button_mask,
	output logic                    push,
	output item_t                   item
);

	op_t op;

	// frame ticks run regardless of focus; everything else drops without it
	always_comb begin
		op = OP_NOP;
		if (cmd_t'(cmd) == CMD_FRAME) begin
			op = OP_FRAME;
		end else if (focused) begin
			unique case (cmd_t'(cmd))
				CMD_MOVE:        op = OP_MOVE;
				CMD_LDOWN:       op = OP_LDOWN;
				CMD_LUP:         op = OP_LUP;
				CMD_RDOWN:       op = OP_RDOWN;
				CMD_RUP:         op = OP_RUP;
				CMD_WHEEL:       op = OP_WHEEL;
				CMD_HELD_HIT:    op = OP_HIT_HELD;
				CMD_CLICK_HIT:   op = OP_HIT_CLICK;
				CMD_CURSOR_HIT:  op = OP_HIT_CURSOR;
				CMD_FORCE_CLICK: op = OP_FORCE_CLICK;
				CMD_FORCE_HELD:  op = OP_FORCE_HELD;
				default:         op = OP_NOP;
			endcase
		end
	end

	always_comb begin
		item.op           = op;
		item.pos_x        = pos_x;
		item.pos_y        = pos_y;
		item.move_buttons = move_buttons;
		item.wheel_in     = wheel_in;
		item.rect_left    = rect_left;
		item.rect_top     = rect_top;
		item.rect_right   = rect_right;
		item.rect_bottom  = rect_bottom;
		item.button_mask  = button_mask;
	end

	assign push = in_valid && !q_stat.full;

endmodule
`default_nettype wire

@@ design/pevb_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pevb_queue: decoupling queue
// Small FIFO of decoded items between the classifier and the executor.
// ----------------------------------------------------------------------------
module pevb_queue
	import pevb_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_ctrl_t q_ctrl,
	input  wire item_t   wr_item,
	output q_stat_t      q_stat,
	output item_t        rd_item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	item_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign q_stat.full  = (count_q == FULL_CNT);
	assign q_stat.empty = (count_q == '0);
	assign do_push      = q_ctrl.push && !q_stat.full;
	assign do_pop       = q_ctrl.pop && !q_stat.empty;
	assign rd_item      = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == FULL_CNT) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with count");
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(do_pop && !do_push && count_q == CNT_W'(1)) |=> q_stat.empty)
		else $error("queue did not drain");
`endif

endmodule
`default_nettype wire

@@ design/pevb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pevb_back: event executor
// Holds live, ring and frame state, runs one queued item a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module pevb_back
	import pevb_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire q_stat_t             q_stat,
	input  wire item_t               q_item,
	output q_ctrl_t                  q_ctrl,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [15:0]       cursor_x,
	output logic signed [15:0]       cursor_y,
	output logic [1:0]               held_now,
	output logic [1:0]               clicked_now,
	output logic signed [15:0]       wheel_out,
	output logic                     hit
);

	localparam int SLOT_W = $clog2(RING_DEPTH);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);

	logic [1:0]         ring_buttons_q [RING_DEPTH];
	logic signed [15:0] ring_x_q [RING_DEPTH];
	logic signed [15:0] ring_y_q [RING_DEPTH];

	logic [1:0]         live_buttons_q, live_buttons_n;
	logic signed [15:0] live_x_q, live_x_n;
	logic signed [15:0] live_y_q, live_y_n;
	logic signed [15:0] pending_wheel_q, pending_wheel_n;
	logic [1:0]         newest_buttons_q;
	logic [SLOT_W-1:0]  write_slot_q;
	logic [SLOT_W-1:0]  read_slot_q, read_slot_n;
	logic signed [15:0] frame_x_q, frame_x_n;
	logic signed [15:0] frame_y_q, frame_y_n;
	logic [1:0]         frame_buttons_q, frame_buttons_n;
	logic [1:0]         frame_clicked_q, frame_clicked_n;
	logic signed [15:0] frame_wheel_q, frame_wheel_n;
	logic               out_valid_q;
	logic               hit_q, hit_n;
	logic               exec;
	logic               button_op;
	logic               push;
	logic               in_rect;
	logic               is_hit_op;

	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
		next_slot = (s == LAST_SLOT) ? '0 : s + 1'b1;
	endfunction

	assign exec          = !q_stat.empty && (!out_valid_q || !out_stall);
	assign q_ctrl.pop    = exec;
	assign q_ctrl.push   = 1'b0;

	assign in_rect = (frame_x_q >= q_item.rect_left) && (frame_x_q <= q_item.rect_right)
		&& (frame_y_q >= q_item.rect_top) && (frame_y_q <= q_item.rect_bottom);

	assign is_hit_op = (q_item.op == OP_HIT_HELD) || (q_item.op == OP_HIT_CLICK)
		|| (q_item.op == OP_HIT_CURSOR);

	always_comb begin
		live_buttons_n  = live_buttons_q;
		live_x_n        = live_x_q;
		live_y_n        = live_y_q;
		pending_wheel_n = pending_wheel_q;
		read_slot_n     = read_slot_q;
		frame_x_n       = frame_x_q;
		frame_y_n       = frame_y_q;
		frame_buttons_n = frame_buttons_q;
		frame_clicked_n = frame_clicked_q;
		frame_wheel_n   = frame_wheel_q;
		button_op       = 1'b0;
		hit_n           = 1'b0;
		unique case (q_item.op)
			OP_MOVE: begin
				live_x_n       = q_item.pos_x;
				live_y_n       = q_item.pos_y;
				live_buttons_n = q_item.move_buttons;
				button_op      = 1'b1;
			end
			OP_LDOWN: begin
				live_buttons_n = live_buttons_q | 2'b01;
				button_op      = 1'b1;
			end
			OP_LUP: begin
				live_buttons_n = live_buttons_q & 2'b10;
				button_op      = 1'b1;
			end
			OP_RDOWN: begin
				live_buttons_n = live_buttons_q | 2'b10;
				button_op      = 1'b1;
			end
			OP_RUP: begin
				live_buttons_n = live_buttons_q & 2'b01;
				button_op      = 1'b1;
			end
			OP_WHEEL: pending_wheel_n = q_item.wheel_in;
			OP_FRAME: begin
				frame_wheel_n   = pending_wheel_q;
				pending_wheel_n = '0;
				if (read_slot_q != write_slot_q) begin
					frame_x_n       = ring_x_q[read_slot_q];
					frame_y_n       = ring_y_q[read_slot_q];
					frame_buttons_n = ring_buttons_q[read_slot_q];
					read_slot_n     = next_slot(read_slot_q);
				end else begin
					frame_x_n       = live_x_q;
					frame_y_n       = live_y_q;
					frame_buttons_n = live_buttons_q;
				end
				frame_clicked_n = frame_buttons_n & ~frame_buttons_q;
			end
			OP_HIT_HELD:    hit_n = in_rect && |(frame_buttons_q & q_item.button_mask);
			OP_HIT_CLICK:   hit_n = in_rect && |(frame_clicked_q & q_item.button_mask);
			OP_HIT_CURSOR:  hit_n = in_rect;
			OP_FORCE_CLICK: frame_clicked_n = frame_clicked_q | q_item.button_mask;
			OP_FORCE_HELD:  frame_buttons_n = frame_buttons_q | q_item.button_mask;
			OP_NOP: ;
			default: ;
		endcase
	end

	// push only when the buttons moved away from the newest ring entry
	assign push = button_op && (live_buttons_n != newest_buttons_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_buttons_q   <= '0;
			live_x_q         <= '0;
			live_y_q         <= '0;
			pending_wheel_q  <= '0;
			newest_buttons_q <= '0;
			write_slot_q     <= '0;
			read_slot_q      <= '0;
			frame_x_q        <= FRAME_X_RESET;
			frame_y_q        <= FRAME_Y_RESET;
			frame_buttons_q  <= '0;
			frame_clicked_q  <= '0;
			frame_wheel_q    <= '0;
			out_valid_q      <= 1'b0;
			hit_q            <= 1'b0;
		end else begin
			if (exec) begin
				live_buttons_q  <= live_buttons_n;
				live_x_q        <= live_x_n;
				live_y_q        <= live_y_n;
				pending_wheel_q <= pending_wheel_n;
				read_slot_q     <= read_slot_n;
				frame_x_q       <= frame_x_n;
				frame_y_q       <= frame_y_n;
				frame_buttons_q <= frame_buttons_n;
				frame_clicked_q <= frame_clicked_n;
				frame_wheel_q   <= frame_wheel_n;
				hit_q           <= hit_n;
				out_valid_q     <= 1'b1;
				if (push) begin
					write_slot_q     <= next_slot(write_slot_q);
					newest_buttons_q <= live_buttons_n;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec && push) begin
			ring_buttons_q[write_slot_q] <= live_buttons_n;
			ring_x_q[write_slot_q]       <= live_x_n;
			ring_y_q[write_slot_q]       <= live_y_n;
		end
	end

	assign out_valid   = out_valid_q;
	assign cursor_x    = frame_x_q;
	assign cursor_y    = frame_y_q;
	assign held_now    = frame_buttons_q;
	assign clicked_now = frame_clicked_q;
	assign wheel_out   = frame_wheel_q;
	assign hit         = hit_q;

`ifndef SYNTHESIS
	a_slots_range: assert property (@(posedge clk) disable iff (!arst_n)
		write_slot_q <= LAST_SLOT && read_slot_q <= LAST_SLOT)
		else $error("ring slot out of range");
	a_hit_only_tests: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && !is_hit_op) |=> !hit_q)
		else $error("hit raised by a non hit-test item");
	a_newest_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(exec && push) |=> newest_buttons_q == ring_buttons_q[$past(write_slot_q)])
		else $error("newest button copy out of step with ring");
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!exec |=> $stable(frame_x_q) && $stable(write_slot_q) && $stable(read_slot_q))
		else $error("state changed without an item");
`endif

endmodule
`default_nettype wire

@@ design/pointer_event_buffer.sv @@
`default_nettype none
// Path: an accepted item is stored in the queue and, unless out_stall holds it, executed into the result registers.
// Throughput: one item per cycle while the queue holds items and out_stall does not hold a pending result.
// Stalls: a two-entry queue between classifier and executor absorbs output back-pressure.
// Reset: frame cursor goes to (320, 240), all other state to zero, ring empty.
// Ring storage is never read before it is written, so reset needs no clearing pass.
// ----------------------------------------------------------------------------
// pointer_event_buffer: pointer input buffer with a short event ring
// Classifies pointer commands, queues them and executes them on live,
// ring and per-frame state, returning the frame state after each item.
// ----------------------------------------------------------------------------
module pointer_event_buffer
	import pevb_pkg::*;
#(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// input item channel
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         cmd,
	input  wire logic               focused,
	input  wire logic signed [15:0] pos_x,
	input  wire logic signed [15:0] pos_y,
	input  wire logic [1:0]         move_buttons,
	input  wire logic signed [15:0] wheel_in,
	input  wire logic signed [15:0] rect_left,
	input  wire logic signed [15:0] rect_top,
	input  wire logic signed [15:0] rect_right,
	input  wire logic signed [15:0] rect_bottom,
	input  wire logic [1:0]         button_mask,
	// result item channel
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      cursor_x,
	output logic signed [15:0]      cursor_y,
	output logic [1:0]              held_now,
	output logic [1:0]              clicked_now,
	output logic signed [15:0]      wheel_out,
	output logic                    hit
);

	q_stat_t q_stat;
	q_ctrl_t q_ctrl;
	q_ctrl_t back_ctrl;
	item_t   front_item;
	item_t   back_item;
	logic    front_push;

	// stall straight from the registered queue fill, never from out_stall
	assign in_stall = q_stat.full;

	// classify: fold focus into the decoded operation
	pevb_front u_front (
		.in_valid     (in_valid),
		.q_stat       (q_stat),
		.cmd          (cmd),
		.focused      (focused),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.move_buttons (move_buttons),
		.wheel_in     (wheel_in),
		.rect_left    (rect_left),
		.rect_top     (rect_top),
		.rect_right   (rect_right),
		.rect_bottom  (rect_bottom),
		.button_mask  (button_mask),
		.push         (front_push),
		.item         (front_item)
	);

	// merge push from the front with pop from the back
	always_comb begin
		q_ctrl.push = front_push;
		q_ctrl.pop  = back_ctrl.pop;
	end

	pevb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_ctrl  (q_ctrl),
		.wr_item (front_item),
		.q_stat  (q_stat),
		.rd_item (back_item)
	);

	// execute: advance live, ring and frame state, hold the result
	pevb_back #(
		.RING_DEPTH (RING_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.q_item      (back_item),
		.q_ctrl      (back_ctrl),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cursor_x    (cursor_x),
		.cursor_y    (cursor_y),
		.held_now    (held_now),
		.clicked_now (clicked_now),
		.wheel_out   (wheel_out),
		.hit         (hit)
	);

endmodule
`default_nettype wire
